// ===== sv/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// Shared codes, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int KEY_BITS   = 64;
  localparam int BC_BITS    = 9;
  localparam int COUNT_BITS = 11;
  localparam int FOUND_BITS = 32;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_FIND   = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_CLR, S_CLRD, S_HEAD, S_HEADW, S_CHECK,
    S_CMP, S_ALLOCW, S_INS1, S_INS2, S_DEL1, S_DEL2, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SWEEP, CMD_CLR_DONE, CMD_BIDX, CMD_HEAD_RD,
    CMD_HEAD_LD, CMD_NODE_RD, CMD_ADVANCE, CMD_FIND_HIT, CMD_PRESENT,
    CMD_MISS, CMD_FULL, CMD_ALLOC_RD, CMD_ALLOC_FREE, CMD_ALLOC_FRESH,
    CMD_INS_NODE, CMD_INS_LINK, CMD_DEL_HIT, CMD_DEL_LINK, CMD_DEL_FREE,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic [1:0] func;
    logic       div_done;
    logic       sweep_last;
    logic       cur_null;
    logic       key_match;
    logic       free_null;
    logic       fresh_full;
    logic       out_busy;
  } sts_t;

endpackage

// ===== sv/chm_in_if.sv =====
// ----------------------------------------------------------------------------
// chm_in_if
// Request channel: operation, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface chm_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [63:0]           key;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

// ===== sv/chm_out_if.sv =====
// ----------------------------------------------------------------------------
// chm_out_if
// Result channel: status, found value and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface chm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [10:0] entry_count;
  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

// ===== sv/chm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// chm_cfg_if
// Configuration write channel carrying the bucket count.
// ----------------------------------------------------------------------------
interface chm_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/chm_moddiv.sv =====
// ----------------------------------------------------------------------------
// chm_moddiv
// Bit-serial restoring remainder: 64-bit dividend modulo a 9-bit divisor.
// ----------------------------------------------------------------------------
module chm_moddiv import chm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [KEY_BITS-1:0]  dividend,
  input  logic [BC_BITS-1:0]   divisor,
  output logic                 done,
  output logic [BC_BITS-1:0]   rem
);
  logic [6:0]          cnt_r;
  logic                done_r;
  logic [BC_BITS-1:0]  rem_r, rem_nxt;
  logic [KEY_BITS-1:0] q_r;
  logic [BC_BITS:0]    trial;

  always_comb begin
    trial = {rem_r, q_r[KEY_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = BC_BITS'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[BC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 7'(KEY_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[KEY_BITS-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

// ===== sv/chm_dp.sv =====
// ----------------------------------------------------------------------------
// chm_dp
// Datapath: bucket head and node memories, pool state, result register.
// ----------------------------------------------------------------------------
module chm_dp import chm_pkg::*; #(
  parameter int NUM_BUCKETS = 256,
  parameter int NUM_NODES   = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic [1:0]            in_func,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  cfg_we,
  input  logic [BC_BITS-1:0]    cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [FOUND_BITS-1:0] out_found,
  output logic [COUNT_BITS-1:0] out_count
);
  localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NW  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int LW  = $clog2(NUM_NODES + 1);
  localparam int CAP = (NUM_BUCKETS < 511) ? NUM_BUCKETS : 511;
  localparam logic [LW-1:0] NIL = LW'(NUM_NODES);

  logic [LW-1:0]         heads_mem [NUM_BUCKETS];
  logic [KEY_BITS-1:0]   keys_mem  [NUM_NODES];
  logic [VALUE_BITS-1:0] vals_mem  [NUM_NODES];
  logic [LW-1:0]         links_mem [NUM_NODES];

  logic [BC_BITS-1:0]    bc_r, bc_eff;
  logic [1:0]            func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BW-1:0]         bidx_r, sweep_r;
  logic [LW-1:0]         cur_r, prev_r, next_r, n_r, free_r, fresh_r, ent_r;
  logic [1:0]            res_st_r;
  logic [VALUE_BITS-1:0] res_val_r;
  logic                  out_valid_r;
  logic [1:0]            out_st_r;
  logic [FOUND_BITS-1:0] out_found_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic [LW-1:0]         head_rd;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [LW-1:0]         link_rd;

  logic                  div_done;
  logic [BC_BITS-1:0]    div_rem;

  logic                  hw_en, lw_en, nw_en, rd_en;
  logic [BW-1:0]         hw_addr;
  logic [LW-1:0]         hw_data, lw_data;
  logic [NW-1:0]         lw_addr, rd_addr;
  cmd_t                  cmd;

  assign cmd = ctl.cmd;

  always_comb begin
    if (bc_r == '0) begin
      bc_eff = BC_BITS'(1);
    end else if (bc_r > BC_BITS'(CAP)) begin
      bc_eff = BC_BITS'(CAP);
    end else begin
      bc_eff = bc_r;
    end
  end

  chm_moddiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd == CMD_LOAD),
    .dividend (in_key),
    .divisor  (bc_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // memory port steering
  always_comb begin
    hw_en   = 1'b0;
    hw_addr = bidx_r;
    hw_data = NIL;
    lw_en   = 1'b0;
    lw_addr = NW'(cur_r);
    lw_data = NIL;
    nw_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = NW'(cur_r);
    case (cmd)
      CMD_SWEEP: begin
        hw_en   = 1'b1;
        hw_addr = sweep_r;
      end
      CMD_NODE_RD: begin
        rd_en = 1'b1;
      end
      CMD_ALLOC_RD: begin
        rd_en   = 1'b1;
        rd_addr = NW'(free_r);
      end
      CMD_INS_NODE: begin
        nw_en   = 1'b1;
        lw_en   = 1'b1;
        lw_addr = NW'(n_r);
      end
      CMD_INS_LINK: begin
        if (prev_r != NIL) begin
          lw_en   = 1'b1;
          lw_addr = NW'(prev_r);
          lw_data = n_r;
        end else begin
          hw_en   = 1'b1;
          hw_data = n_r;
        end
      end
      CMD_DEL_LINK: begin
        if (prev_r != NIL) begin
          lw_en   = 1'b1;
          lw_addr = NW'(prev_r);
          lw_data = next_r;
        end else begin
          hw_en   = 1'b1;
          hw_data = next_r;
        end
      end
      CMD_DEL_FREE: begin
        lw_en   = 1'b1;
        lw_data = free_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heads_mem[hw_addr] <= hw_data;
    end
    if (cmd == CMD_HEAD_RD) begin
      head_rd <= heads_mem[bidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) begin
      keys_mem[NW'(n_r)] <= key_r;
      vals_mem[NW'(n_r)] <= val_r;
    end
    if (rd_en) begin
      key_rd <= keys_mem[rd_addr];
      val_rd <= vals_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      links_mem[lw_addr] <= lw_data;
    end
    if (rd_en) begin
      link_rd <= links_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r        <= BC_BITS'(256);
      sweep_r     <= '0;
      free_r      <= NIL;
      fresh_r     <= '0;
      ent_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bc_r <= cfg_data;
      end
      // a new result is only posted once the old beat has left
      if (cmd == CMD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_SWEEP: begin
          sweep_r <= (sweep_r == BW'(NUM_BUCKETS - 1)) ? '0 : sweep_r + BW'(1);
        end
        CMD_CLR_DONE: begin
          free_r  <= NIL;
          fresh_r <= '0;
          ent_r   <= '0;
        end
        CMD_ALLOC_FREE: begin
          free_r <= link_rd;
        end
        CMD_ALLOC_FRESH: begin
          fresh_r <= fresh_r + LW'(1);
        end
        CMD_INS_LINK: begin
          ent_r <= ent_r + LW'(1);
        end
        CMD_DEL_FREE: begin
          free_r <= cur_r;
          if (ent_r != '0) begin
            ent_r <= ent_r - LW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        func_r    <= in_func;
        key_r     <= in_key;
        val_r     <= in_value;
        res_st_r  <= ST_OK;
        res_val_r <= '0;
      end
      CMD_BIDX:     bidx_r <= BW'(div_rem);
      CMD_HEAD_LD: begin
        cur_r  <= head_rd;
        prev_r <= NIL;
      end
      CMD_ADVANCE: begin
        prev_r <= cur_r;
        cur_r  <= link_rd;
      end
      CMD_FIND_HIT:    res_val_r <= val_rd;
      CMD_PRESENT:     res_st_r  <= ST_PRESENT;
      CMD_MISS:        res_st_r  <= ST_ABSENT;
      CMD_FULL:        res_st_r  <= ST_FULL;
      CMD_ALLOC_FREE:  n_r       <= free_r;
      CMD_ALLOC_FRESH: n_r       <= fresh_r;
      CMD_DEL_HIT:     next_r    <= link_rd;
      CMD_OUT: begin
        out_st_r    <= res_st_r;
        out_found_r <= FOUND_BITS'(res_val_r);
        out_count_r <= COUNT_BITS'(ent_r);
      end
      default: begin
      end
    endcase
  end

  assign sts.func       = func_r;
  assign sts.div_done   = div_done;
  assign sts.sweep_last = (sweep_r == BW'(NUM_BUCKETS - 1));
  assign sts.cur_null   = (cur_r == NIL);
  assign sts.key_match  = (key_rd == key_r);
  assign sts.free_null  = (free_r == NIL);
  assign sts.fresh_full = (fresh_r == NIL);
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_st_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

`ifndef SYNTHESIS
  a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_r <= NIL) else $error("entry count above pool size");
  a_fresh_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_ALLOC_FRESH |=> fresh_r == $past(fresh_r) + LW'(1))
    else $error("fresh counter did not advance");
  a_ins_node: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_INS_NODE |-> n_r != NIL) else $error("insert without node");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_OUT |=> out_valid_r) else $error("result not presented");
`endif
endmodule

// ===== sv/chm_ctrl.sv =====
// ----------------------------------------------------------------------------
// chm_ctrl
// Controller: sequences reset sweep, divide, clear, chain walk, allocate/unlink and result.
// ----------------------------------------------------------------------------
module chm_ctrl import chm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.cmd   = CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        ctl.cmd = CMD_SWEEP;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd   = CMD_LOAD;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.func == FN_CLEAR) begin
          state_nxt = S_CLR;
        end else if (sts.div_done) begin
          ctl.cmd   = CMD_BIDX;
          state_nxt = S_HEAD;
        end
      end
      S_CLR: begin
        ctl.cmd = CMD_SWEEP;
        if (sts.sweep_last) state_nxt = S_CLRD;
      end
      S_CLRD: begin
        ctl.cmd   = CMD_CLR_DONE;
        state_nxt = S_FIN;
      end
      S_HEAD: begin
        ctl.cmd   = CMD_HEAD_RD;
        state_nxt = S_HEADW;
      end
      S_HEADW: begin
        ctl.cmd   = CMD_HEAD_LD;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.cur_null) begin
          ctl.cmd   = CMD_NODE_RD;
          state_nxt = S_CMP;
        end else if (sts.func != FN_INSERT) begin
          ctl.cmd   = CMD_MISS;
          state_nxt = S_FIN;
        end else if (!sts.free_null) begin
          ctl.cmd   = CMD_ALLOC_RD;
          state_nxt = S_ALLOCW;
        end else if (!sts.fresh_full) begin
          ctl.cmd   = CMD_ALLOC_FRESH;
          state_nxt = S_INS1;
        end else begin
          ctl.cmd   = CMD_FULL;
          state_nxt = S_FIN;
        end
      end
      S_CMP: begin
        if (!sts.key_match) begin
          ctl.cmd   = CMD_ADVANCE;
          state_nxt = S_CHECK;
        end else if (sts.func == FN_INSERT) begin
          ctl.cmd   = CMD_PRESENT;
          state_nxt = S_FIN;
        end else if (sts.func == FN_DELETE) begin
          ctl.cmd   = CMD_DEL_HIT;
          state_nxt = S_DEL1;
        end else begin
          ctl.cmd   = CMD_FIND_HIT;
          state_nxt = S_FIN;
        end
      end
      S_ALLOCW: begin
        ctl.cmd   = CMD_ALLOC_FREE;
        state_nxt = S_INS1;
      end
      S_INS1: begin
        ctl.cmd   = CMD_INS_NODE;
        state_nxt = S_INS2;
      end
      S_INS2: begin
        ctl.cmd   = CMD_INS_LINK;
        state_nxt = S_FIN;
      end
      S_DEL1: begin
        ctl.cmd   = CMD_DEL_LINK;
        state_nxt = S_DEL2;
      end
      S_DEL2: begin
        ctl.cmd   = CMD_DEL_FREE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.cmd   = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.out_busy || state_r == S_IDLE) else $error("ready outside idle");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && !sts.out_busy |=> state_r == S_IDLE)
    else $error("finish did not return to idle");
  a_ins_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS1 |=> state_r == S_INS2) else $error("insert link skipped");
`endif
endmodule

// ===== sv/chained_hash_map.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map
// Separate-chaining hash map from 64-bit keys to value handles over a
// fixed node pool, with free list, insert/delete/find/clear.
// ----------------------------------------------------------------------------
//  channel  dir  payload                               beat when
//  in_ch    in   func, key, value                      valid && ready
//  out_ch   out  status, found_value, entry_count      valid && ready
//  cfg_ch   in   data (bucket count)                   valid && ready
//
//  Steps: insert/delete/find run a 64-step serial key modulo, a head read, a
//  walk over the chain nodes visited, an allocate or unlink where needed, then
//  post the result and return to idle. Clear sweeps every head, one head per cycle.
//  Reset: synchronous rst_n, then a head clearing pass over all NUM_BUCKETS heads
//  with in_ch.ready low. cfg_ch is always ready.
//  Stalls: a waiting result lets the next request run; it then holds until the beat is gone.
// ----------------------------------------------------------------------------
module chained_hash_map import chm_pkg::*; #(
  parameter int NUM_BUCKETS = 256,
  parameter int NUM_NODES   = 1024,
  parameter int VALUE_BITS  = 32
) (
  input logic       clk,
  input logic       rst_n,
  chm_in_if.sink    in_ch,
  chm_out_if.source out_ch,
  chm_cfg_if.sink   cfg_ch
);
  ctl_t ctl;
  sts_t sts;

  // bucket count register takes every write beat
  assign cfg_ch.ready = 1'b1;

  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  chm_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_NODES   (NUM_NODES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_func    (in_ch.func),
    .in_key     (in_ch.key),
    .in_value   (in_ch.value),
    .cfg_we     (cfg_ch.valid),
    .cfg_data   (cfg_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_found  (out_ch.found_value),
    .out_count  (out_ch.entry_count)
  );
endmodule

// ===== sim/chained_hash_map_tb.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_tb
// Self-checking bench for the chained hash map: a shadow map predicts each
// result beat, random gaps on both channels, bucket count set to values across its range.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chained_hash_map_tb;
  import chm_pkg::*;

  localparam int NB = 256;
  localparam int NN = 1024;
  localparam logic [10:0] NIL = 11'(NN);
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [10:0] entry_count;
  } map_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  chm_in_if  #(.VALUE_BITS(32)) in_ch ();
  chm_out_if out_ch ();
  chm_cfg_if cfg_ch ();

  chained_hash_map DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the map state.
  logic [8:0]  shadow_bc;
  logic [10:0] shadow_heads [NB];
  logic [63:0] shadow_keys  [NN];
  logic [31:0] shadow_vals  [NN];
  logic [10:0] shadow_links [NN];
  logic [10:0] shadow_fresh;
  logic [10:0] shadow_free;
  logic [10:0] shadow_count;

  map_result_t expected_results [$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  hold_out = 1'b0;
  bit  out_gaps = 1'b1;
  logic [63:0] live_keys [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void clear_shadow();
    for (int i = 0; i < NB; i++) shadow_heads[i] = NIL;
    shadow_fresh = '0;
    shadow_free  = NIL;
    shadow_count = '0;
  endfunction

  function automatic int bucket_index(input logic [63:0] key);
    int unsigned bc;
    bc = shadow_bc;
    if (bc == 0) bc = 1;
    if (bc > NB) bc = NB;
    return int'(key % 64'(bc));
  endfunction

  // Chain walk: node holding key or NIL, prev = node before it / tail.
  function automatic logic [10:0] chain_search(input int b, input logic [63:0] key,
                                               output logic [10:0] prev);
    logic [10:0] cur;
    int steps;
    cur = shadow_heads[b];
    steps = 0;
    prev = NIL;
    while (cur < NIL && steps < NN) begin
      if (shadow_keys[cur] == key) return cur;
      prev = cur;
      cur = shadow_links[cur];
      steps++;
    end
    return NIL;
  endfunction

  function automatic map_result_t predict_map_op(input logic [1:0] func,
                                                 input logic [63:0] key,
                                                 input logic [31:0] value);
    map_result_t r;
    logic [10:0] prev, node, n;
    int b;
    r = '{status: ST_OK, found_value: '0, entry_count: '0};
    b = bucket_index(key);
    case (func)
      FN_INSERT: begin
        node = chain_search(b, key, prev);
        if (node < NIL) begin
          r.status = ST_PRESENT;
        end else begin
          if (shadow_free < NIL) begin
            n = shadow_free;
            shadow_free = shadow_links[n];
          end else if (shadow_fresh < NN) begin
            n = shadow_fresh;
            shadow_fresh++;
          end else begin
            n = NIL;
          end
          if (n >= NIL) begin
            r.status = ST_FULL;
          end else begin
            shadow_keys[n] = key;
            shadow_vals[n] = value;
            shadow_links[n] = NIL;
            if (prev < NIL) shadow_links[prev] = n;
            else shadow_heads[b] = n;
            shadow_count++;
          end
        end
      end
      FN_DELETE: begin
        node = chain_search(b, key, prev);
        if (node >= NIL) begin
          r.status = ST_ABSENT;
        end else begin
          if (prev < NIL) shadow_links[prev] = shadow_links[node];
          else shadow_heads[b] = shadow_links[node];
          shadow_links[node] = shadow_free;
          shadow_free = node;
          if (shadow_count > 0) shadow_count--;
        end
      end
      FN_FIND: begin
        node = chain_search(b, key, prev);
        if (node >= NIL) r.status = ST_ABSENT;
        else r.found_value = shadow_vals[node];
      end
      default: clear_shadow();
    endcase
    r.entry_count = shadow_count;
    return r;
  endfunction

  // Short gaps mostly, a long one now and then.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid is driven low between requests.
  task automatic send_request(input logic [1:0] func, input logic [63:0] key,
                              input logic [31:0] value, input bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    repeat (g + 1) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.key   <= key;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_map_op(func, key, value));
    if (func == FN_INSERT) live_keys.push_back(key);
    if (func == FN_CLEAR) live_keys.delete();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    // Every result, clears included, has arrived; the map then sits idle.
    repeat (NB + 300) @(negedge clk);
  endtask

  task automatic write_bucket_count(input logic [8:0] bc);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= bc;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_bc = bc;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Live keys and a small key set recur, so hits are common and chains grow long under small bucket counts.
  function automatic logic [63:0] pick_key();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40 && live_keys.size() != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if (p < 70) return 64'($urandom_range(0, 63));
    return rand_key();
  endfunction

  task automatic test_directed_ops();
    send_request(FN_FIND, 64'd0, 32'd0, 1'b0);
    send_request(FN_DELETE, 64'd0, 32'd0, 1'b0);
    send_request(FN_INSERT, 64'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(FN_INSERT, '1, 32'h0, 1'b0);
    send_request(FN_INSERT, 64'd256, 32'h1234_5678, 1'b0);   // same bucket as 0
    send_request(FN_INSERT, 64'd512, 32'hA5A5_5A5A, 1'b0);
    send_request(FN_INSERT, 64'd256, 32'hDEAD_BEEF, 1'b0);   // already present
    send_request(FN_FIND, 64'd256, 32'h0, 1'b0);
    send_request(FN_FIND, '1, 32'h0, 1'b0);
    send_request(FN_DELETE, 64'd256, 32'h0, 1'b0);           // middle of chain
    send_request(FN_FIND, 64'd512, 32'h0, 1'b0);
    send_request(FN_DELETE, 64'd0, 32'h0, 1'b0);             // chain head
    send_request(FN_INSERT, 64'h8000_0000_0000_0000, 32'h5555_AAAA, 1'b0); // reuse
    send_request(FN_FIND, 64'h8000_0000_0000_0000, 32'h0, 1'b0);
    send_request(FN_CLEAR, rand_key(), $urandom(), 1'b0);
    send_request(FN_FIND, 64'd512, 32'h0, 1'b0);
    wait_drained();
  endtask

  task automatic test_bucket_extremes();
    // One bucket, then zero (acts as one), then over range (saturates).
    write_bucket_count(9'd1);
    for (int i = 0; i < 6; i++) send_request(FN_INSERT, 64'(i * 7), $urandom(), 1'b0);
    send_request(FN_FIND, 64'd35, 32'h0, 1'b0);
    send_request(FN_DELETE, 64'd14, 32'h0, 1'b0);
    wait_drained();
    write_bucket_count(9'd0);
    send_request(FN_FIND, 64'd21, 32'h0, 1'b0);
    wait_drained();
    // Stale chains: lookups under another count may miss.
    write_bucket_count(9'd511);
    send_request(FN_FIND, 64'd21, 32'h0, 1'b0);
    send_request(FN_INSERT, 64'd21, 32'h77, 1'b0);
    send_request(FN_CLEAR, 64'd0, 32'h0, 1'b0);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (400) @(negedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_request(FN_INSERT, pick_key(), $urandom(), 1'b0);
    join
    wait_drained();
  endtask

  task automatic test_random_ops(input int count);
    logic [8:0] bc_set [4];
    bc_set = '{9'd1, 9'd7, 9'd200, 9'd256};
    for (int phase = 0; phase < 4; phase++) begin
      write_bucket_count(bc_set[phase]);
      out_gaps = (phase != 2);
      for (int i = 0; i < count / 4; i++) begin
        logic [1:0] f;
        int p;
        p = $urandom_range(0, 99);
        f = p < 45 ? FN_INSERT : p < 70 ? FN_DELETE : p < 98 ? FN_FIND : FN_CLEAR;
        send_request(f, pick_key(), $urandom(), phase != 2);
      end
      wait_drained();
    end
    out_gaps = 1'b1;
  endtask

  // Result checker and receiver-side stalls.
  initial begin
    map_result_t want;
    int g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      g = (out_gaps && !hold_out) ? pick_gap() : 0;
      while (hold_out) @(negedge clk);
      repeat (g) @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_ch.status), 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.found_value !== want.found_value)
          report_mismatch("found_value", out_ch.found_value, want.found_value);
        if (out_ch.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_ch.entry_count), 32'(want.entry_count));
      end
      @(negedge clk);
      out_ch.ready <= 1'b0;
    end
  end

  // Watchdog: cycles without any beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.func   = FN_FIND;
    in_ch.key    = '0;
    in_ch.value  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = 9'd256;
    shadow_bc    = 9'd256;
    clear_shadow();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed_ops();
    test_bucket_extremes();
    test_output_backpressure();
    test_random_ops(500);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
